/* hdl/msp_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot pixel package
// Shared widths, register codes, payload types and the colour ramp for the
// escape-time pixel block.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int FracBits = 28;
  localparam int CoordW   = FracBits + 4;
  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int IdxW  = 10;
  localparam int IterW = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLimit   = 3'd4;

  typedef struct packed {
    logic [IdxW-1:0] column;
    logic [IdxW-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [IterW-1:0] iterations_done;
    logic             inside_res;
  } pix_out_t;

  // Work handed from the front end to the iteration engine.
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } pt_t;

  // Colour for a 17-bit Q1.16 position.
  function automatic logic [23:0] ramp(input logic [16:0] pos);
    logic [19:0] m7;
    logic [2:0]  n;
    logic [23:0] tm;
    logic [7:0]  t;
    logic [7:0]  it;
    m7 = 20'(pos) * 20'd7;
    n  = m7[18:16];
    tm = 24'(m7[15:0]) * 24'd255;
    t  = tm[23:16];
    it = 8'd255 - t;
    unique case (n)
      3'd0:    ramp = {8'd0,   t,     8'd255};
      3'd1:    ramp = {8'd0,   it,    8'd255};
      3'd2:    ramp = {t,      8'd255, 8'd0};
      3'd3:    ramp = {8'd255, it,    8'd0};
      3'd4:    ramp = {t,      8'd0,  8'd255};
      3'd5:    ramp = {8'd255, 8'd0,  it};
      default: ramp = {8'd255, 8'd0,  8'd0};
    endcase
  endfunction

endpackage

/* hdl/msp_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one packed payload word.
// ----------------------------------------------------------------------------
interface msp_stream_if #(parameter int W = 20);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/msp_front.sv */
// ----------------------------------------------------------------------------
// Mandelbrot front end
// Maps the pixel index to point c over two stages and saturates c.
// ----------------------------------------------------------------------------
module msp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  msp_pkg::pix_in_t                  in_data_i,
  input  logic signed [31:0]                origin_x_i,
  input  logic signed [31:0]                origin_y_i,
  input  logic [30:0]                       step_x_i,
  input  logic [30:0]                       step_y_i,
  output logic                              pt_valid_o,
  input  logic                              pt_ready_i,
  output msp_pkg::pt_t                      pt_o
);
  localparam int W = msp_pkg::CoordW;
  logic        s1_q;
  logic [41:0] px_q, py_q;
  logic        s2_q;
  msp_pkg::pt_t pt_q;
  logic signed [43:0] cx, cy, acy, hi, lo;
  logic s1_adv;

  assign s1_adv     = !s2_q || pt_ready_i;
  assign in_ready_o = !s1_q || s1_adv;
  assign pt_valid_o = s2_q;
  assign pt_o       = pt_q;

  always_comb begin
    hi = 44'sd2 ** (W - 1) - 44'sd1;
    lo = -hi - 44'sd1;
    cx = 44'(origin_x_i) + $signed({2'b0, px_q});
    cy = 44'(origin_y_i) + $signed({2'b0, py_q});
    acy = cy < 0 ? -cy : cy;
    if ((acy <<< 1) < $signed({13'd0, step_y_i})) cy = '0;
    if (cx > hi) cx = hi; else if (cx < lo) cx = lo;
    if (cy > hi) cy = hi; else if (cy < lo) cy = lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_q <= in_valid_i;
      if (s1_adv) s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      px_q <= 42'(in_data_i.column) * 42'(step_x_i);
      py_q <= 42'(in_data_i.row) * 42'(step_y_i);
    end
    if (s1_adv && s1_q) begin
      pt_q.cx <= W'(cx);
      pt_q.cy <= W'(cy);
    end
  end
endmodule

/* hdl/msp_queue.sv */
// ----------------------------------------------------------------------------
// Mandelbrot point queue
// Two-entry queue between the front end and the iteration engine.
// ----------------------------------------------------------------------------
module msp_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  msp_pkg::pt_t wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output msp_pkg::pt_t rd_data_o
);
  msp_pkg::pt_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* hdl/msp_engine.sv */
// ----------------------------------------------------------------------------
// Mandelbrot iteration engine
// Runs the escape loop one step per pass through SMul and SAdd, then the
// smooth colour sequence.
// ----------------------------------------------------------------------------
module msp_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pt_valid_i,
  output logic                    pt_ready_o,
  input  msp_pkg::pt_t            pt_i,
  input  logic [15:0]             limit_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output msp_pkg::pix_out_t       out_o
);
  localparam int W  = msp_pkg::CoordW;
  localparam int FB = msp_pkg::FracBits;
  // z can reach about three times the coordinate range after one step, and
  // its squares need eight more integer bits than c.
  localparam int ZW = W + 2;
  localparam int SW = W + 8;
  localparam logic [3:0] SIdle = 4'd0, SMul = 4'd1, SAdd = 4'd2, SLog1 = 4'd3,
                         SLog2 = 4'd4, SDiv = 4'd5, SCol = 4'd6, SOut = 4'd7;
  localparam logic [SW-1:0] Bail = SW'(64'd4 << FB);

  logic [3:0] st_q;
  logic signed [W-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] zx_q, zy_q;
  logic signed [SW-1:0] zx2_q, zy2_q, zxy_q;
  logic [15:0] iter_q, lim_q;
  logic [39:0] num_q;      // dividend / remainder
  logic [31:0] quo_q;
  logic [5:0]  dcnt_q;
  logic [31:0] l1_q;
  logic [16:0] pos;
  msp_pkg::pix_out_t res_q;

  // Truncated fixed multiply, magnitude rounding toward zero. Operand
  // magnitudes stay below 2^32 whenever a product is taken.
  function automatic logic signed [SW-1:0] fmul(input logic signed [ZW-1:0] a,
                                                input logic signed [ZW-1:0] b);
    logic [W-1:0] ma, mb;
    logic [2*W-1:0] p;
    logic [SW-1:0] r;
    ma = a[ZW-1] ? W'(-a) : W'(a);
    mb = b[ZW-1] ? W'(-b) : W'(b);
    p = (2*W)'(ma) * (2*W)'(mb);
    r = SW'(p >> FB);
    fmul = (a[ZW-1] ^ b[ZW-1]) ? -$signed(r) : $signed(r);
  endfunction

  // Leading-one log2 in Q.16.
  function automatic logic signed [31:0] lg(input logic [SW-1:0] x,
                                            input int fb);
    int p;
    logic [SW+15:0] s;
    p = 0;
    for (int i = 0; i < SW; i++) if (x[i]) p = i;
    s = (SW+16)'(x) << 16;
    s = s >> p;
    lg = (x == '0) ? 32'sd0 : ((32'(p) - 32'(fb)) <<< 16) + 32'(s[15:0]);
  endfunction

  logic [SW-1:0] mag;
  logic signed [SW-1:0] nzy, nzx;
  logic signed [31:0] l2;
  logic signed [40:0] num;
  logic [40:0] trial;

  assign mag = zx2_q + zy2_q;
  assign nzy = (zxy_q <<< 1) + SW'(cy_q);
  assign nzx = zx2_q - zy2_q + SW'(cx_q);
  assign l2  = lg(SW'(l1_q[31] ? 32'd0 : 32'(l1_q >>> 1)), 16);
  assign num = 41'(iter_q) * 41'sd65536 - 41'(l2);
  assign trial = {num_q, quo_q[31]} - {25'd0, lim_q};
  assign pos = (quo_q > 32'd65536) ?
               ((quo_q[15:0] == 16'd0) ? 17'd65536 : {1'b0, quo_q[15:0]}) :
               quo_q[16:0];

  assign pt_ready_o  = st_q == SIdle;
  assign out_valid_o = st_q == SOut;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      unique case (st_q)
        SIdle: if (pt_valid_i) st_q <= (limit_i == 16'd0) ? SOut : SMul;
        SMul:  st_q <= SAdd;
        SAdd:  begin
          if (mag >= Bail) st_q <= SLog1;
          else if (iter_q == lim_q) st_q <= SOut;
          else st_q <= SMul;
        end
        SLog1: st_q <= SLog2;
        SLog2: st_q <= SDiv;
        SDiv:  if (dcnt_q == 6'd0) st_q <= SCol;
        SCol:  st_q <= SOut;
        SOut:  if (out_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        cx_q <= pt_i.cx; cy_q <= pt_i.cy;
        lim_q <= limit_i; iter_q <= '0;
        zx2_q <= '0; zy2_q <= '0; zxy_q <= '0;
        res_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0,
                   iterations_done: 16'd0, inside_res: 1'b1};
      end
      SMul: begin
        // Check bailout and limit before the step, as the loop does.
        if (mag < Bail && iter_q != lim_q) begin
          zy_q <= ZW'(nzy);
          zx_q <= ZW'(nzx);
          iter_q <= iter_q + 16'd1;
        end
      end
      SAdd: begin
        if (mag < Bail && iter_q != 16'd0 && !(iter_q == lim_q)) begin
          zx2_q <= fmul(zx_q, zx_q);
          zy2_q <= fmul(zy_q, zy_q);
          zxy_q <= fmul(zx_q, zy_q);
        end
        res_q.iterations_done <= iter_q;
        res_q.inside_res <= 1'b1;
      end
      SLog1: l1_q <= lg(mag, FB);
      SLog2: begin
        num_q <= '0;
        quo_q <= (num > 0) ? 32'(num) : 32'd0;
        dcnt_q <= 6'd31;
      end
      SDiv: begin
        if (!trial[40]) begin
          num_q <= trial[39:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          num_q <= {num_q[38:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end
      SCol: begin
        {res_q.red, res_q.green, res_q.blue} <= msp_pkg::ramp(pos);
        res_q.inside_res <= 1'b0;
      end
      default: ;
    endcase
  end
endmodule

/* hdl/mandelbrot_smooth_pixel_colour.sv */
// ----------------------------------------------------------------------------
// Mandelbrot smooth pixel colour
// Maps a pixel to point c, runs the escape loop and returns a smooth colour.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// in_if     in   column, row
// out_if    out  red, green, blue, iterations_done, inside_res
// cfg_*     in   register index and data, written without a wait
//
// Each escape iteration passes through the engine's SMul and SAdd states. An
// escaped pixel then runs the logs, the bit-serial divide and the colour ramp;
// the iteration engine sets the rate.
// The front end maps the next pixel while the engine works, and a two-word
// queue sits between them. Reset loads the default view and limit 1000.
module mandelbrot_smooth_pixel_colour (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [msp_pkg::CfgDataW-1:0]    cfg_data_i,
  msp_stream_if.sink                      in_if,
  msp_stream_if.source                    out_if
);
  logic signed [31:0] ox_q, oy_q;
  logic [30:0] sx_q, sy_q;
  logic [15:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= -32'sd671088640;
      oy_q <= -32'sd402653184;
      sx_q <= 31'd1771675;
      sy_q <= 31'd1610613;
      lim_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msp_pkg::RegOriginX: ox_q <= cfg_data_i;
        msp_pkg::RegOriginY: oy_q <= cfg_data_i;
        msp_pkg::RegStepX:   sx_q <= cfg_data_i[30:0];
        msp_pkg::RegStepY:   sy_q <= cfg_data_i[30:0];
        msp_pkg::RegLimit:   lim_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, e_valid, e_ready;
  msp_pkg::pt_t f_pt, e_pt;
  msp_pkg::pix_in_t in_w;
  msp_pkg::pix_out_t out_w;
  assign in_w = in_if.data;
  assign out_if.data = out_w;

  msp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_w),
    .origin_x_i(ox_q), .origin_y_i(oy_q), .step_x_i(sx_q), .step_y_i(sy_q),
    .pt_valid_o(f_valid), .pt_ready_i(f_ready), .pt_o(f_pt)
  );

  msp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_pt),
    .rd_valid_o(e_valid), .rd_ready_i(e_ready), .rd_data_o(e_pt)
  );

  msp_engine u_engine (
    .clk_i, .rst_ni,
    .pt_valid_i(e_valid), .pt_ready_o(e_ready), .pt_i(e_pt), .limit_i(lim_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_o(out_w)
  );
endmodule

/* dv/tb_mandelbrot_smooth_pixel_colour.sv */
// ----------------------------------------------------------------------------
// Mandelbrot smooth pixel colour testbench
// Sends pixel words through the input stream and checks every colour word
// against an in-bench predictor of the escape loop and the colour ramp.
// Covers the default view, limit extremes, saturated coordinates, the
// row snap, a long output hold-off and randomized views with random gaps.
// ----------------------------------------------------------------------------
module tb_mandelbrot_smooth_pixel_colour;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [msp_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [msp_pkg::CfgDataW-1:0] cfg_data_i;

  msp_stream_if #(.W($bits(msp_pkg::pix_in_t)))  in_ch ();
  msp_stream_if #(.W($bits(msp_pkg::pix_out_t))) out_ch ();

  mandelbrot_smooth_pixel_colour dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run ends here if the block hangs; this is far above the slowest
  // correct run.
  initial begin
    #6ms;
    $display("FAILURE");
    $finish;
  end

  // Shadow copy of the view registers, updated whenever a view is loaded.
  logic [31:0] view_ox;
  logic [31:0] view_oy;
  logic [30:0] view_sx;
  logic [30:0] view_sy;
  logic [15:0] view_limit;

  msp_pkg::pix_out_t pending_colours[$];
  int errors;
  int pixels_sent;
  int pixels_inside;
  int pixels_escaped;

  // Gap percentages for both sides, and a hold-off request for the receiver.
  int send_gap_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Fixed-point product: exact magnitude product, truncated, sign reapplied.
  function automatic longint fx_product(input longint a, input longint b);
    logic [127:0] full;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  mag;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    full = {64'd0, ma} * {64'd0, mb};
    mag = 64'(full >> msp_pkg::FracBits);
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  // Leading-one log2 with a truncated 16-bit linear mantissa, in Q.16.
  function automatic longint log2_q16(input logic [63:0] x, input int fb);
    int p;
    logic [63:0] mant;
    if (x == 0) return 0;
    p = 63;
    while (!x[p]) p--;
    if (p >= 16) mant = (x >> (p - 16)) & 64'hFFFF;
    else mant = (x << (16 - p)) & 64'hFFFF;
    return longint'(p - fb) * 65536 + longint'(mant);
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint hi;
    hi = (longint'(1) << (msp_pkg::FracBits + 3)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Works out the colour word that one pixel must produce under the view.
  function automatic msp_pkg::pix_out_t predict_colour(input logic [9:0] col,
                                                       input logic [9:0] row);
    msp_pkg::pix_out_t res;
    longint cx, cy, zx, zy, zx2, zy2, bail, l1, l2, num, lim, pos, m7, band, t;
    int iter;
    lim = longint'(view_limit);
    cx = longint'($signed(view_ox)) + longint'(col) * longint'(view_sx);
    cy = longint'($signed(view_oy)) + longint'(row) * longint'(view_sy);
    // Rows within half a step of the real axis land exactly on it.
    if (((cy < 0) ? -cy : cy) * 2 < longint'(view_sy)) cy = 0;
    cx = clamp_coord(cx);
    cy = clamp_coord(cy);
    zx = 0; zy = 0; zx2 = 0; zy2 = 0;
    bail = longint'(4) << msp_pkg::FracBits;
    iter = 0;
    while (iter < lim && zx2 + zy2 < bail) begin
      zy = 2 * fx_product(zx, zy) + cy;
      zx = zx2 - zy2 + cx;
      zx2 = fx_product(zx, zx);
      zy2 = fx_product(zy, zy);
      iter++;
    end
    res = '0;
    res.iterations_done = 16'(iter);
    res.inside_res = (iter >= lim);
    if (iter < lim) begin
      l1 = log2_q16(64'(zx2 + zy2), msp_pkg::FracBits);
      l2 = log2_q16(64'((l1 < 0) ? 0 : l1 / 2), 16);
      num = longint'(iter) * 65536 - l2;
      pos = (num > 0) ? num / lim : 0;
      // Positions past one wrap to their fraction; an exact wrap stays at one.
      if (pos > 65536) begin
        pos = pos & 65535;
        if (pos == 0) pos = 65536;
      end
      m7 = 7 * pos;
      band = m7 >> 16;
      t = ((m7 & 65535) * 255) >> 16;
      case (band)
        0: begin res.red = 0; res.green = 8'(t); res.blue = 255; end
        1: begin res.red = 0; res.green = 8'(255 - t); res.blue = 255; end
        2: begin res.red = 8'(t); res.green = 255; res.blue = 0; end
        3: begin res.red = 255; res.green = 8'(255 - t); res.blue = 0; end
        4: begin res.red = 8'(t); res.green = 0; res.blue = 255; end
        5: begin res.red = 255; res.green = 0; res.blue = 8'(255 - t); end
        default: begin res.red = 255; res.green = 0; res.blue = 0; end
      endcase
    end
    return res;
  endfunction

  // Receiver: checks each accepted word against the oldest expectation and
  // then picks ready for the next cycle.
  msp_pkg::pix_out_t got_word;
  msp_pkg::pix_out_t want_word;
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      got_word = out_ch.data;
      if (pending_colours.size() == 0) begin
        report_mismatch("colour word arrived with nothing expected");
      end else begin
        want_word = pending_colours.pop_front();
        if (got_word.red !== want_word.red)
          report_mismatch($sformatf("red %0d, expected %0d", got_word.red, want_word.red));
        if (got_word.green !== want_word.green)
          report_mismatch($sformatf("green %0d, expected %0d",
                                    got_word.green, want_word.green));
        if (got_word.blue !== want_word.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got_word.blue, want_word.blue));
        if (got_word.iterations_done !== want_word.iterations_done)
          report_mismatch($sformatf("iterations_done %0d, expected %0d",
                                    got_word.iterations_done, want_word.iterations_done));
        if (got_word.inside_res !== want_word.inside_res)
          report_mismatch($sformatf("inside_res %0b, expected %0b",
                                    got_word.inside_res, want_word.inside_res));
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one pixel word, waits for it to be taken and records the
  // expected colour. Valid stays high when the next word follows at once.
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    msp_pkg::pix_in_t word;
    msp_pkg::pix_out_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    word.column = col;
    word.row = row;
    in_ch.valid <= 1'b1;
    in_ch.data <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    want = predict_colour(col, row);
    pending_colours.push_back(want);
    pixels_sent++;
    if (want.inside_res) pixels_inside++;
    else pixels_escaped++;
  endtask

  // Lowers valid and waits until every colour word is back, then lets the
  // engine settle before the view may change.
  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_colours.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  // Writes all five registers, one per cycle, while the block is idle.
  task automatic load_view(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [30:0] sx, input logic [30:0] sy,
                           input logic [15:0] lim);
    logic [msp_pkg::CfgIdxW-1:0] idx [5];
    logic [31:0] val [5];
    idx = '{msp_pkg::RegOriginX, msp_pkg::RegOriginY, msp_pkg::RegStepX,
            msp_pkg::RegStepY, msp_pkg::RegLimit};
    val = '{ox, oy, {1'b0, sx}, {1'b0, sy}, {16'd0, lim}};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    view_ox = ox;
    view_oy = oy;
    view_sx = sx;
    view_sy = sy;
    view_limit = lim;
    @(posedge clk_i);
  endtask

  task automatic set_gaps(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Default view after reset: image corners, an interior point, and the
  // row that lies within half a step of the real axis and snaps onto it.
  task automatic test_reset_view();
    set_gaps(0, 0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd380, 10'd250);
    send_pixel(10'd300, 10'd250);
    send_pixel(10'd700, 10'd250);
    send_pixel(10'd341, 10'd682);
    drain_pixels();
  endtask

  // Limit extremes: zero counts every pixel as interior, one allows a single
  // step, and the largest limit runs on a saturated view that escapes at once
  // with a smooth value below zero, which clamps the position to zero.
  task automatic test_limit_extremes();
    load_view(32'hD800_0000, 32'hE800_0000, 31'd1771675, 31'd1610613, 16'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd380, 10'd250);
    drain_pixels();
    load_view(32'hD800_0000, 32'hE800_0000, 31'd1771675, 31'd1610613, 16'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd380, 10'd250);
    send_pixel(10'd1023, 10'd1023);
    drain_pixels();
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0, 16'hFFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd1);
    drain_pixels();
    // Row 512 is less than half a step off the axis and snaps; row 511 is not.
    load_view(32'h8000_0000, 32'(-512 * 2000000 + 700000), 31'd4000000, 31'd2000000,
              16'd40);
    send_pixel(10'd0, 10'd512);
    send_pixel(10'd300, 10'd512);
    send_pixel(10'd340, 10'd512);
    send_pixel(10'd360, 10'd511);
    drain_pixels();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the queue fills and the input stalls.
  task automatic test_output_hold_off();
    load_view(32'hD800_0000, 32'hE800_0000, 31'd1771675, 31'd1610613, 16'd20);
    set_gaps(0, 0);
    hold_request = 3000;
    for (int i = 0; i < 12; i++)
      send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
    drain_pixels();
  endtask

  // Random views around the set with small limits, plus a few fully random
  // register values, under each gap pattern in turn.
  task automatic test_random_views();
    int gaps [4][2];
    logic [31:0] ox, oy;
    logic [30:0] sx, sy;
    logic [15:0] lim;
    gaps = '{'{0, 0}, '{60, 0}, '{0, 60}, '{7, 7}};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 4) begin
        ox = $urandom;
        oy = $urandom;
        sx = 31'($urandom);
        sy = 31'($urandom);
      end else begin
        ox = 32'(-671088640 + int'($urandom_range(1 << 28)) - (1 << 27));
        oy = 32'(-402653184 + int'($urandom_range(1 << 27)) - (1 << 26));
        sx = 31'($urandom_range(1 << 21, 1 << 18));
        sy = 31'($urandom_range(1 << 21, 1 << 18));
      end
      lim = (phase == 5) ? 16'd1 : 16'($urandom_range(64, 2));
      load_view(ox, oy, sx, sy, lim);
      set_gaps(gaps[phase % 4][0], gaps[phase % 4][1]);
      for (int i = 0; i < 100; i++)
        send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      // After each phase the sender waits until every word is back.
      drain_pixels();
    end
  endtask

  initial begin
    errors = 0;
    pixels_sent = 0;
    pixels_inside = 0;
    pixels_escaped = 0;
    hold_request = 0;
    hold_left = 0;
    set_gaps(0, 0);
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= msp_pkg::RegOriginX;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    view_ox = 32'hD800_0000;
    view_oy = 32'hE800_0000;
    view_sx = 31'd1771675;
    view_sy = 31'd1610613;
    view_limit = 16'd1000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_limit_extremes();
    test_output_hold_off();
    test_random_views();

    repeat (100) @(posedge clk_i);
    $display("Checked %0d pixels: %0d escaped, %0d interior.",
             pixels_sent, pixels_escaped, pixels_inside);
    $display("Views: default, limit extremes, saturated and snapped coordinates, random.");
    if (errors == 0 && pending_colours.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
